// ===== sv/sasf_pkg.sv =====
package sasf_pkg;

  localparam int SOURCES = 64;
  localparam int IDX_W = $clog2(SOURCES);
  localparam int CNT_W = $clog2(SOURCES + 1);

  localparam logic [31:0] MAGIC_WORD = 32'hAABBCCDD;
  localparam logic [7:0] ALT_FLAG = 8'h02;
  localparam logic [15:0] CH_MAX = 16'd5;

  localparam logic [2:0] REG_EVICT = 3'd0;
  localparam logic [2:0] REG_ENC = 3'd1;
  localparam logic [2:0] REG_HIGH = 3'd2;
  localparam logic [2:0] REG_MED = 3'd3;
  localparam logic [2:0] REG_WEIGHT = 3'd4;

  localparam logic [1:0] VERDICT_PASS = 2'd0;
  localparam logic [1:0] VERDICT_HIGH = 2'd1;
  localparam logic [1:0] VERDICT_MED = 2'd2;

  // key part of an entry, stored in the key memory
  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port;
  } key_t;

  // status part of an entry, stored in the status memory
  typedef struct packed {
    logic [63:0] last_seen;
    logic [31:0] bad_count;
    logic [15:0] score;
  } stat_t;

  typedef struct packed {
    logic [7:0] enc_code;
    logic [15:0] high_thr;
    logic [15:0] med_thr;
    logic [7:0] weight;
  } cfg_t;

endpackage

// ===== sv/sasf_table.sv =====
// Entry storage: key memory and status memory, one read and one write port each.
module sasf_table (
  input  logic                     clk,
  input  logic                     key_we,
  input  logic [sasf_pkg::IDX_W-1:0] key_waddr,
  input  sasf_pkg::key_t           key_wdata,
  input  logic [sasf_pkg::IDX_W-1:0] key_raddr,
  output sasf_pkg::key_t           key_rdata,
  input  logic                     st_we,
  input  logic [sasf_pkg::IDX_W-1:0] st_waddr,
  input  sasf_pkg::stat_t          st_wdata,
  input  logic [sasf_pkg::IDX_W-1:0] st_raddr,
  output sasf_pkg::stat_t          st_rdata
);

  sasf_pkg::key_t  key_mem [sasf_pkg::SOURCES];
  sasf_pkg::stat_t st_mem  [sasf_pkg::SOURCES];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rdata <= st_mem[st_raddr];
  end

endmodule

// ===== sv/sasf_score.sv =====
// Header check and score update for one entry; one registered multiply stage.
module sasf_score (
  input  logic            clk,
  input  logic            load,
  input  sasf_pkg::cfg_t  cfg,
  input  sasf_pkg::stat_t st_in,
  input  logic [31:0]     magic,
  input  logic [7:0]      version,
  input  logic [7:0]      hdr_flags,
  input  logic [15:0]     channel,
  input  logic [31:0]     seq_num,
  output logic [31:0]     bad_count_r,
  output logic [15:0]     score_r
);

  logic        bad;
  logic [31:0] cnt_inc;
  logic [39:0] prod;

  assign bad = (magic != sasf_pkg::MAGIC_WORD) || (version != 8'd1) ||
               ((hdr_flags != 8'd0) && (hdr_flags != cfg.enc_code) &&
                (hdr_flags != sasf_pkg::ALT_FLAG)) ||
               (channel < 16'd1) || (channel > sasf_pkg::CH_MAX) ||
               (seq_num == 32'd0);

  assign cnt_inc = (st_in.bad_count != 32'hFFFF_FFFF) ? st_in.bad_count + 32'd1
                                                        : st_in.bad_count;
  assign prod = {8'd0, cnt_inc} * {32'd0, cfg.weight};

  always_ff @(posedge clk) begin
    if (load) begin
      if (bad) begin
        bad_count_r <= cnt_inc;
        score_r <= (prod > 40'd65535) ? 16'hFFFF : prod[15:0];
      end else begin
        bad_count_r <= st_in.bad_count;
        score_r <= (st_in.score != 16'd0) ? st_in.score - 16'd1 : st_in.score;
      end
    end
  end

endmodule

// ===== sv/source_anomaly_score_filter.sv =====
// Source anomaly score filter.
// Issue a packet header with start high while busy is low; the fields on the
// in_ ports are taken at that edge. Exactly one result follows, shown for a
// single cycle with out_valid high; the receiver cannot stall it.
// Per item the sequencer reads the key memory once per stored entry to find
// the source, one entry a cycle. When the table is full and the eviction
// interval has passed, a second pass over the status memory finds the oldest
// entry, and the last entry is copied over it. Busy stays high until out_valid.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// the user must issue them only while busy is low; the block does not enforce it.
// Reset (rst_n low, synchronous) empties the table, clears the drop counters
// and the eviction time, and loads the register defaults. No clearing pass.
module source_anomaly_score_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_has_address,
  input  logic [63:0] in_addr_high,
  input  logic [63:0] in_addr_low,
  input  logic [15:0] in_src_port,
  input  logic [63:0] in_now_ms,
  input  logic [31:0] in_magic,
  input  logic [7:0]  in_version,
  input  logic [7:0]  in_hdr_flags,
  input  logic [15:0] in_channel,
  input  logic [31:0] in_seq_num,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_verdict,
  output logic        out_tracked,
  output logic [15:0] out_source_score,
  output logic [31:0] out_high_drop_count,
  output logic [31:0] out_medium_drop_count
);

  localparam int IW = sasf_pkg::IDX_W;
  localparam int CW = sasf_pkg::CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_MIN  = 4'd2;
  localparam logic [3:0] S_CPYK = 4'd3;
  localparam logic [3:0] S_CPYS = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_RDW  = 4'd6;
  localparam logic [3:0] S_SC   = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;

  logic [3:0] state_r;
  logic [31:0] evict_r;
  sasf_pkg::cfg_t cfg_r;
  logic [CW-1:0] count_r;
  logic [63:0] last_evict_r;
  logic [31:0] high_r, med_r;

  sasf_pkg::key_t key_in_r;
  logic [63:0] now_r;
  logic [31:0] magic_r, seq_r;
  logic [7:0] version_r, flags_r;
  logic [15:0] channel_r;

  logic [CW-1:0] ra_r;     // address issued
  logic          rv_r;     // a read was issued last cycle
  logic [IW-1:0] rq_r;     // address of the data now out of memory
  logic [IW-1:0] slot_r;
  logic          fresh_r;  // slot is a new entry
  logic [IW-1:0] pick_r;
  logic [63:0]   best_r;

  logic key_we, st_we;
  logic [IW-1:0] key_waddr, st_waddr, key_raddr, st_raddr;
  sasf_pkg::key_t key_wdata, key_rdata;
  sasf_pkg::stat_t st_wdata, st_rdata;
  logic [31:0] bc_new;
  logic [15:0] sc_new;
  logic load_sc;

  sasf_table u_table (
    .clk(clk), .key_we(key_we), .key_waddr(key_waddr), .key_wdata(key_wdata),
    .key_raddr(key_raddr), .key_rdata(key_rdata), .st_we(st_we),
    .st_waddr(st_waddr), .st_wdata(st_wdata), .st_raddr(st_raddr),
    .st_rdata(st_rdata)
  );

  sasf_score u_score (
    .clk(clk), .load(load_sc), .cfg(cfg_r), .st_in(fresh_r ? '0 : st_rdata),
    .magic(magic_r), .version(version_r), .hdr_flags(flags_r),
    .channel(channel_r), .seq_num(seq_r), .bad_count_r(bc_new), .score_r(sc_new)
  );

  localparam logic [IW-1:0] LAST = IW'(sasf_pkg::SOURCES - 1);
  localparam logic [CW-1:0] FULL = CW'(sasf_pkg::SOURCES);

  logic can_evict;
  assign can_evict = (now_r - last_evict_r) >= {32'd0, evict_r};
  assign busy = (state_r != S_IDLE);
  assign load_sc = (state_r == S_RDW);

  always_comb begin
    key_we = 1'b0; st_we = 1'b0;
    key_waddr = slot_r; st_waddr = slot_r;
    key_wdata = key_in_r; st_wdata = '0;
    key_raddr = ra_r[IW-1:0]; st_raddr = ra_r[IW-1:0];
    case (state_r)
      S_CPYK: begin
        key_raddr = LAST; st_raddr = LAST;
      end
      S_CPYS: begin
        key_we = 1'b1; st_we = 1'b1;
        key_waddr = pick_r; st_waddr = pick_r;
        key_wdata = key_rdata; st_wdata = st_rdata;
      end
      S_RD: begin
        st_raddr = slot_r;
        key_we = fresh_r;
      end
      S_WB: begin
        st_we = 1'b1;
        st_wdata = '{last_seen: now_r, bad_count: bc_new, score: sc_new};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      evict_r <= 32'd10000;
      cfg_r <= '{enc_code: 8'd1, high_thr: 16'd100, med_thr: 16'd50, weight: 8'd10};
      count_r <= '0;
      last_evict_r <= '0;
      high_r <= '0;
      med_r <= '0;
      rv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sasf_pkg::REG_EVICT:  evict_r <= cfg_data;
          sasf_pkg::REG_ENC:    cfg_r.enc_code <= cfg_data[7:0];
          sasf_pkg::REG_HIGH:   cfg_r.high_thr <= cfg_data[15:0];
          sasf_pkg::REG_MED:    cfg_r.med_thr <= cfg_data[15:0];
          sasf_pkg::REG_WEIGHT: cfg_r.weight <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            key_in_r <= '{addr_high: in_addr_high, addr_low: in_addr_low,
                          port: in_src_port};
            now_r <= in_now_ms; magic_r <= in_magic; seq_r <= in_seq_num;
            version_r <= in_version; flags_r <= in_hdr_flags;
            channel_r <= in_channel;
            ra_r <= '0; rv_r <= 1'b0;
            if (in_has_address) begin
              state_r <= S_SRCH;
            end else begin
              out_valid <= 1'b1;
              out_verdict <= sasf_pkg::VERDICT_PASS;
              out_tracked <= 1'b0;
              out_source_score <= '0;
              out_high_drop_count <= high_r;
              out_medium_drop_count <= med_r;
            end
          end
        end
        S_SRCH: begin
          // compare the entry read last cycle, issue the next read
          rq_r <= ra_r[IW-1:0];
          rv_r <= (ra_r < count_r);
          if (rv_r && key_rdata == key_in_r) begin
            slot_r <= rq_r; fresh_r <= 1'b0; state_r <= S_RD;
          end else if (!(ra_r < count_r) && !rv_r) begin
            if (count_r != FULL) begin
              slot_r <= count_r[IW-1:0]; fresh_r <= 1'b1;
              count_r <= count_r + CW'(1); state_r <= S_RD;
            end else if (can_evict) begin
              ra_r <= '0; rv_r <= 1'b0; state_r <= S_MIN;
            end else begin
              out_valid <= 1'b1;
              out_verdict <= sasf_pkg::VERDICT_PASS;
              out_tracked <= 1'b0;
              out_source_score <= '0;
              out_high_drop_count <= high_r;
              out_medium_drop_count <= med_r;
              state_r <= S_IDLE;
            end
          end else begin
            ra_r <= (ra_r < count_r) ? ra_r + CW'(1) : ra_r;
          end
        end
        S_MIN: begin
          rq_r <= ra_r[IW-1:0];
          rv_r <= (ra_r < FULL);
          if (ra_r < FULL) ra_r <= ra_r + CW'(1);
          if (rv_r) begin
            if (rq_r == '0 || st_rdata.last_seen < best_r) begin
              best_r <= st_rdata.last_seen; pick_r <= rq_r;
            end
          end else if (!(ra_r < FULL)) begin
            state_r <= S_CPYK;
          end
        end
        S_CPYK: state_r <= S_CPYS;
        S_CPYS: begin
          last_evict_r <= now_r;
          slot_r <= LAST; fresh_r <= 1'b1;
          state_r <= S_RD;
        end
        S_RD: state_r <= S_RDW;
        S_RDW: state_r <= S_SC;
        S_SC: state_r <= S_WB;
        S_WB: begin
          out_valid <= 1'b1;
          out_tracked <= 1'b1;
          out_source_score <= sc_new;
          out_high_drop_count <= high_r;
          out_medium_drop_count <= med_r;
          if (sc_new >= cfg_r.high_thr) begin
            out_verdict <= sasf_pkg::VERDICT_HIGH;
            if (high_r != 32'hFFFF_FFFF) begin
              high_r <= high_r + 32'd1;
              out_high_drop_count <= high_r + 32'd1;
            end
          end else if (sc_new >= cfg_r.med_thr) begin
            out_verdict <= sasf_pkg::VERDICT_MED;
            if (med_r != 32'hFFFF_FFFF) begin
              med_r <= med_r + 32'd1;
              out_medium_drop_count <= med_r + 32'd1;
            end
          end else begin
            out_verdict <= sasf_pkg::VERDICT_PASS;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL) else $error("entry count above table size");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy || $past(state_r) == S_IDLE) else $error("result while busy");
  a_drop_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> high_r >= $past(high_r)) else $error("high drop count fell");
  a_untracked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tracked |-> out_verdict == sasf_pkg::VERDICT_PASS &&
    out_source_score == 16'd0) else $error("untracked result not a pass");

endmodule

// ===== tb/sv/sasf_checker.sv =====
`timescale 1ns / 1ps

module sasf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_has_address,
  input  logic [63:0] in_addr_high,
  input  logic [63:0] in_addr_low,
  input  logic [15:0] in_src_port,
  input  logic [63:0] in_now_ms,
  input  logic [31:0] in_magic,
  input  logic [7:0]  in_version,
  input  logic [7:0]  in_hdr_flags,
  input  logic [15:0] in_channel,
  input  logic [31:0] in_seq_num,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        out_valid,
  input  logic [1:0]  out_verdict,
  input  logic        out_tracked,
  input  logic [15:0] out_source_score,
  input  logic [31:0] out_high_drop_count,
  input  logic [31:0] out_medium_drop_count,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  verdict;
    logic        tracked;
    logic [15:0] score;
    logic [31:0] high_cnt;
    logic [31:0] med_cnt;
  } verdict_t;

  sasf_pkg::key_t  src_key [sasf_pkg::SOURCES];
  sasf_pkg::stat_t src_stat [sasf_pkg::SOURCES];
  int              src_used;
  logic [63:0]     last_evict;
  logic [31:0]     high_drops, med_drops;
  logic [31:0]     evict_gap;
  sasf_pkg::cfg_t  filt_cfg;
  verdict_t        verdict_q[$];

  assign pending = verdict_q.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic int find_source(sasf_pkg::key_t k, logic [63:0] now);
    int pick;
    logic [63:0] oldest;
    for (int i = 0; i < src_used; i++)
      if (src_key[i] == k) return i;
    if (src_used >= sasf_pkg::SOURCES && (now - last_evict) >= {32'd0, evict_gap}) begin
      pick = 0;
      oldest = src_stat[0].last_seen;
      for (int i = 1; i < sasf_pkg::SOURCES; i++)
        if (src_stat[i].last_seen < oldest) begin
          pick = i;
          oldest = src_stat[i].last_seen;
        end
      // move the last entry into the evicted slot
      src_key[pick] = src_key[sasf_pkg::SOURCES-1];
      src_stat[pick] = src_stat[sasf_pkg::SOURCES-1];
      src_used = sasf_pkg::SOURCES - 1;
      last_evict = now;
    end
    if (src_used >= sasf_pkg::SOURCES) return -1;
    src_key[src_used] = k;
    src_stat[src_used] = '{last_seen: now, bad_count: 32'd0, score: 16'd0};
    src_used++;
    return src_used - 1;
  endfunction

  function automatic verdict_t score_packet();
    verdict_t v;
    int slot;
    logic bad;
    logic [63:0] prod;
    sasf_pkg::key_t k;
    v = '0;
    slot = -1;
    k = '{addr_high: in_addr_high, addr_low: in_addr_low, port: in_src_port};
    if (in_has_address) slot = find_source(k, in_now_ms);
    if (slot >= 0) begin
      v.tracked = 1'b1;
      src_stat[slot].last_seen = in_now_ms;
      bad = (in_magic != sasf_pkg::MAGIC_WORD) || (in_version != 8'd1) ||
            (in_hdr_flags != 8'd0 && in_hdr_flags != filt_cfg.enc_code &&
             in_hdr_flags != sasf_pkg::ALT_FLAG) ||
            (in_channel < 16'd1) || (in_channel > sasf_pkg::CH_MAX) ||
            (in_seq_num == 32'd0);
      if (bad) begin
        if (src_stat[slot].bad_count != '1) src_stat[slot].bad_count++;
        prod = {32'd0, src_stat[slot].bad_count} * {56'd0, filt_cfg.weight};
        src_stat[slot].score = (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
      end else if (src_stat[slot].score != 16'd0) begin
        src_stat[slot].score--;
      end
      v.score = src_stat[slot].score;
      if (v.score >= filt_cfg.high_thr) begin
        v.verdict = sasf_pkg::VERDICT_HIGH;
        if (high_drops != '1) high_drops++;
      end else if (v.score >= filt_cfg.med_thr) begin
        v.verdict = sasf_pkg::VERDICT_MED;
        if (med_drops != '1) med_drops++;
      end
    end
    v.high_cnt = high_drops;
    v.med_cnt = med_drops;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      fail_count = 0;
      src_used = 0;
      last_evict = '0;
      high_drops = '0;
      med_drops = '0;
      evict_gap = 32'd10000;
      filt_cfg = '{enc_code: 8'd1, high_thr: 16'd100, med_thr: 16'd50, weight: 8'd10};
      verdict_q.delete();
    end else begin
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'd0);
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want.verdict)
            report_mismatch("verdict", 64'(out_verdict), 64'(want.verdict));
          if (out_tracked !== want.tracked)
            report_mismatch("tracked", 64'(out_tracked), 64'(want.tracked));
          if (out_source_score !== want.score)
            report_mismatch("source_score", 64'(out_source_score), 64'(want.score));
          if (out_high_drop_count !== want.high_cnt)
            report_mismatch("high_drop_count", 64'(out_high_drop_count),
                            64'(want.high_cnt));
          if (out_medium_drop_count !== want.med_cnt)
            report_mismatch("medium_drop_count", 64'(out_medium_drop_count),
                            64'(want.med_cnt));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          sasf_pkg::REG_EVICT:  evict_gap = cfg_data;
          sasf_pkg::REG_ENC:    filt_cfg.enc_code = cfg_data[7:0];
          sasf_pkg::REG_HIGH:   filt_cfg.high_thr = cfg_data[15:0];
          sasf_pkg::REG_MED:    filt_cfg.med_thr = cfg_data[15:0];
          sasf_pkg::REG_WEIGHT: filt_cfg.weight = cfg_data[7:0];
          default: ;
        endcase
      end
      if (start && !busy) verdict_q.push_back(score_packet());
    end
  end

endmodule

// ===== tb/sv/tb_source_anomaly_score_filter.sv =====
`timescale 1ns / 1ps

module tb_source_anomaly_score_filter;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_has_address = 1'b0;
  logic [63:0] in_addr_high = '0;
  logic [63:0] in_addr_low = '0;
  logic [15:0] in_src_port = '0;
  logic [63:0] in_now_ms = '0;
  logic [31:0] in_magic = '0;
  logic [7:0]  in_version = '0;
  logic [7:0]  in_hdr_flags = '0;
  logic [15:0] in_channel = '0;
  logic [31:0] in_seq_num = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        out_valid;
  logic [1:0]  out_verdict;
  logic        out_tracked;
  logic [15:0] out_source_score;
  logic [31:0] out_high_drop_count;
  logic [31:0] out_medium_drop_count;
  int          fail_count;
  int          pending;

  logic [63:0] clock_ms = 64'd1000;
  int          burst_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  source_anomaly_score_filter dut (.*);
  sasf_checker chk (.*);

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // hold until the block is idle and nothing is outstanding
  task automatic drain();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (2 * sasf_pkg::SOURCES + 20) @(negedge clk);
  endtask

  task automatic send_packet(input logic has, input logic [63:0] ah, input logic [63:0] al,
                             input logic [15:0] port, input logic [63:0] now,
                             input logic [31:0] mg, input logic [7:0] ver,
                             input logic [7:0] fl, input logic [15:0] ch,
                             input logic [31:0] sq);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    in_has_address <= has;
    in_addr_high <= ah;
    in_addr_low <= al;
    in_src_port <= port;
    in_now_ms <= now;
    in_magic <= mg;
    in_version <= ver;
    in_hdr_flags <= fl;
    in_channel <= ch;
    in_seq_num <= sq;
    // busy at a falling edge is what the next rising edge sees
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic good_packet(input logic [7:0] src, input logic [63:0] now);
    send_packet(1'b1, 64'd0, {56'd0, src}, 16'd80, now, sasf_pkg::MAGIC_WORD, 8'd1, 8'd0,
                16'd1, 32'd7);
  endtask

  // mostly well-formed headers from a small source pool, with targeted anomalies
  task automatic random_packet(input int pool);
    logic [63:0] ah, al;
    logic [15:0] port;
    logic [31:0] mg, sq;
    logic [7:0] ver, fl;
    logic [15:0] ch;
    int sel;
    sel = $urandom_range(0, pool - 1);
    if ($urandom_range(0, 9) == 0) begin
      ah = {$urandom, $urandom};
      al = {$urandom, $urandom};
      port = 16'($urandom);
    end else begin
      ah = (sel % 5 == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
      al = (sel % 3 == 0) ? {32'hA5A5_0000, 32'(sel)} : 64'(sel);
      port = 16'(sel % 7) * 16'd9000;
    end
    mg = sasf_pkg::MAGIC_WORD;
    ver = 8'd1;
    fl = 8'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 2));
    ch = 16'($urandom_range(1, 5));
    sq = $urandom | 32'd1;
    case ($urandom_range(0, 11))
      0: mg = $urandom;
      1: ver = 8'($urandom);
      2: fl = 8'($urandom);
      3: ch = 16'($urandom);
      4: sq = 32'd0;
      5: ch = 16'd0;
      default: ;
    endcase
    clock_ms += 64'($urandom_range(0, 400));
    if ($urandom_range(0, 49) == 0) clock_ms = {$urandom, $urandom};
    send_packet($urandom_range(0, 15) != 0, ah, al, port, clock_ms, mg, ver, fl, ch, sq);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: good, every anomaly, field extremes, untracked
    good_packet(8'd1, 64'd100);
    send_packet(1'b1, 64'd0, 64'd1, 16'd80, 64'd101, 32'd0, 8'd1, 8'd0, 16'd1, 32'd7);
    send_packet(1'b1, 64'd0, 64'd1, 16'd80, 64'd102, sasf_pkg::MAGIC_WORD, 8'd255, 8'd0,
                16'd1, 32'd7);
    send_packet(1'b1, 64'd0, 64'd1, 16'd80, 64'd103, sasf_pkg::MAGIC_WORD, 8'd1, 8'd255,
                16'd1, 32'd7);
    send_packet(1'b1, 64'd0, 64'd1, 16'd80, 64'd104, sasf_pkg::MAGIC_WORD, 8'd1, 8'd2,
                16'd0, 32'd7);
    send_packet(1'b1, 64'd0, 64'd1, 16'd80, 64'd105, sasf_pkg::MAGIC_WORD, 8'd1, 8'd1,
                16'hFFFF, 32'd7);
    send_packet(1'b1, 64'd0, 64'd1, 16'd80, 64'd106, sasf_pkg::MAGIC_WORD, 8'd1, 8'd0,
                16'd5, 32'd0);
    send_packet(1'b1, 64'd0, 64'd1, 16'd80, 64'd107, sasf_pkg::MAGIC_WORD, 8'd1, 8'd0,
                16'd6, 32'hFFFF_FFFF);
    good_packet(8'd1, 64'd108);
    send_packet(1'b0, '1, '1, 16'hFFFF, '1, sasf_pkg::MAGIC_WORD, 8'd1, 8'd0, 16'd1, 32'd1);
    send_packet(1'b1, '1, '1, 16'hFFFF, '1, '1, 8'd0, 8'd3, 16'd1, 32'd1);
    send_packet(1'b1, '1, '1, 16'hFFFF, 64'd5, '1, 8'd0, 8'd3, 16'd1, 32'd1);
    drain();

    // configuration extremes: zero thresholds, max weight, alternate encrypted code
    write_reg(sasf_pkg::REG_HIGH, 32'd0);
    write_reg(sasf_pkg::REG_MED, 32'd0);
    write_reg(sasf_pkg::REG_WEIGHT, 32'd255);
    write_reg(sasf_pkg::REG_ENC, 32'd255);
    write_reg(sasf_pkg::REG_EVICT, 32'd0);
    good_packet(8'd2, 64'd200);
    send_packet(1'b1, 64'd0, 64'd2, 16'd80, 64'd201, sasf_pkg::MAGIC_WORD, 8'd1, 8'd255,
                16'd3, 32'd9);
    drain();
    write_reg(sasf_pkg::REG_HIGH, 32'hFFFF);
    for (int i = 0; i < 300; i++)
      send_packet(1'b1, 64'd0, 64'd3, 16'd80, 64'd300 + 64'(i), 32'd0, 8'd1, 8'd0, 16'd1,
                  32'd1);
    drain();

    // fill the table, then evict on every new source (interval zero)
    for (int i = 0; i < sasf_pkg::SOURCES + 8; i++)
      good_packet(8'(10 + i), 64'd1000 + 64'($urandom_range(0, 3)));
    drain();

    write_reg(sasf_pkg::REG_EVICT, 32'hFFFF_FFFF);
    write_reg(sasf_pkg::REG_HIGH, 32'd100);
    write_reg(sasf_pkg::REG_MED, 32'd50);
    write_reg(sasf_pkg::REG_WEIGHT, 32'd10);
    write_reg(sasf_pkg::REG_ENC, 32'd1);
    for (int i = 0; i < 300; i++) random_packet(96);
    drain();

    write_reg(sasf_pkg::REG_EVICT, 32'd300);
    write_reg(sasf_pkg::REG_HIGH, 32'($urandom_range(20, 80)));
    write_reg(sasf_pkg::REG_MED, 32'($urandom_range(5, 30)));
    write_reg(sasf_pkg::REG_WEIGHT, 32'($urandom_range(1, 40)));
    write_reg(sasf_pkg::REG_ENC, 32'($urandom_range(0, 255)));
    for (int i = 0; i < 300; i++) random_packet(($urandom_range(0, 1) == 0) ? 40 : 150);
    drain();

    write_reg(sasf_pkg::REG_EVICT, 32'd10000);
    write_reg(sasf_pkg::REG_MED, 32'hFFFF);
    for (int i = 0; i < 200; i++) random_packet(80);
    drain();

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
